@@ design/voxel_visible_face_culler_unit_assert.svh @@
// assertion macros for the voxel face culler
// plain text macros, no dependencies
`ifndef VOXEL_VISIBLE_FACE_CULLER_UNIT_ASSERT_SVH
`define VOXEL_VISIBLE_FACE_CULLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define VVFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define VVFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/vvfc_pkg.sv @@
// shared constants, tables and microcode of the voxel face culler
// no dependencies
package vvfc_pkg;

  // field widths
  localparam int COORD_W = 5;
  localparam int KIND_W  = 3;
  localparam int CODE_W  = 4;
  localparam int BASE_W  = 6;
  localparam int TEX_W   = 2;
  localparam int FACE_W  = 3;
  localparam int PC_W    = 5;

  // default grid size
  localparam int DEF_GRID_X = 32;
  localparam int DEF_GRID_Y = 32;
  localparam int DEF_GRID_Z = 32;

  // voxel kinds
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GROUND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FLOWER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TRUNK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LEAF   = 3'd4;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // face indices, also the face codes of solid voxels
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd0;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd5;

  // flower cap indices and the code of the first cap
  localparam logic [FACE_W-1:0] CAP_1 = 3'd0;
  localparam logic [FACE_W-1:0] CAP_2 = 3'd1;
  localparam logic [FACE_W-1:0] CAP_3 = 3'd2;
  localparam logic [FACE_W-1:0] CAP_4 = 3'd3;
  localparam logic [CODE_W-1:0] CAP_CODE_FIRST = 4'd6;

  // texture rows in eighths
  localparam logic [TEX_W-1:0] TEX_GROUND = 2'd0;
  localparam logic [TEX_W-1:0] TEX_TRUNK  = 2'd1;
  localparam logic [TEX_W-1:0] TEX_LEAF   = 2'd2;

  // first corner of each quad
  localparam logic [BASE_W-1:0] FACE_BASE [6] = '{6'd20, 6'd0, 6'd4, 6'd8, 6'd12, 6'd16};
  localparam logic [BASE_W-1:0] CAP_BASE  [4] = '{6'd24, 6'd28, 6'd32, 6'd36};

  // result kinds of a step
  typedef enum logic [1:0] {
    EM_NONE = 2'd0,
    EM_FACE = 2'd1,
    EM_CAP  = 2'd2,
    EM_ACK  = 2'd3
  } emit_t;

  // jump conditions
  typedef enum logic [2:0] {
    J_NEVER    = 3'd0,
    J_ALWAYS   = 3'd1,
    J_NOACC    = 3'd2,
    J_BAD      = 3'd3,
    J_FLOWER   = 3'd4,
    J_NOTSOLID = 3'd5,
    J_MASK0    = 3'd6,
    J_LAST     = 3'd7
  } jcond_t;

  // one control word
  typedef struct packed {
    logic              rd_ctr;
    logic              rd_nb;
    logic [FACE_W-1:0] rd_face;
    logic              wr;
    logic              ld_kind;
    logic              cap_open;
    logic [FACE_W-1:0] op_face;
    emit_t             emit;
    jcond_t            jc;
    logic [PC_W-1:0]   target;
  } uword_t;

  // program labels
  localparam logic [PC_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] ST_CHECK = 5'd1;
  localparam logic [PC_W-1:0] ST_RD0   = 5'd2;
  localparam logic [PC_W-1:0] ST_RD1   = 5'd3;
  localparam logic [PC_W-1:0] ST_RD2   = 5'd4;
  localparam logic [PC_W-1:0] ST_RD3   = 5'd5;
  localparam logic [PC_W-1:0] ST_RD4   = 5'd6;
  localparam logic [PC_W-1:0] ST_RD5   = 5'd7;
  localparam logic [PC_W-1:0] ST_TAIL  = 5'd8;
  localparam logic [PC_W-1:0] ST_TEST  = 5'd9;
  localparam logic [PC_W-1:0] ST_EM0   = 5'd10;
  localparam logic [PC_W-1:0] ST_EM1   = 5'd11;
  localparam logic [PC_W-1:0] ST_EM2   = 5'd12;
  localparam logic [PC_W-1:0] ST_EM3   = 5'd13;
  localparam logic [PC_W-1:0] ST_EM4   = 5'd14;
  localparam logic [PC_W-1:0] ST_EM5   = 5'd15;
  localparam logic [PC_W-1:0] ST_CAP0  = 5'd16;
  localparam logic [PC_W-1:0] ST_CAP1  = 5'd17;
  localparam logic [PC_W-1:0] ST_CAP2  = 5'd18;
  localparam logic [PC_W-1:0] ST_CAP3  = 5'd19;
  localparam logic [PC_W-1:0] ST_ACK   = 5'd20;

  localparam uword_t UW_NOP = '{
    rd_ctr: 1'b0, rd_nb: 1'b0, rd_face: FACE_NEG_Z, wr: 1'b0, ld_kind: 1'b0,
    cap_open: 1'b0, op_face: FACE_NEG_Z, emit: EM_NONE, jc: J_NEVER, target: ST_IDLE
  };

  // control program
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = UW_NOP;
    unique case (pc)
      ST_IDLE: begin
        w.jc = J_NOACC; w.target = ST_IDLE;
      end
      ST_CHECK: begin
        w.rd_ctr = 1'b1; w.wr = 1'b1; w.jc = J_BAD; w.target = ST_ACK;
      end
      ST_RD0: begin
        w.rd_nb = 1'b1; w.rd_face = FACE_NEG_Z; w.ld_kind = 1'b1;
        w.jc = J_FLOWER; w.target = ST_CAP0;
      end
      ST_RD1: begin
        w.rd_nb = 1'b1; w.rd_face = FACE_POS_Z;
        w.cap_open = 1'b1; w.op_face = FACE_NEG_Z;
        w.jc = J_NOTSOLID; w.target = ST_ACK;
      end
      ST_RD2: begin
        w.rd_nb = 1'b1; w.rd_face = FACE_POS_X; w.cap_open = 1'b1; w.op_face = FACE_POS_Z;
      end
      ST_RD3: begin
        w.rd_nb = 1'b1; w.rd_face = FACE_NEG_X; w.cap_open = 1'b1; w.op_face = FACE_POS_X;
      end
      ST_RD4: begin
        w.rd_nb = 1'b1; w.rd_face = FACE_POS_Y; w.cap_open = 1'b1; w.op_face = FACE_NEG_X;
      end
      ST_RD5: begin
        w.rd_nb = 1'b1; w.rd_face = FACE_NEG_Y; w.cap_open = 1'b1; w.op_face = FACE_POS_Y;
      end
      ST_TAIL: begin
        w.cap_open = 1'b1; w.op_face = FACE_NEG_Y;
      end
      ST_TEST: begin
        w.jc = J_MASK0; w.target = ST_ACK;
      end
      ST_EM0: begin
        w.emit = EM_FACE; w.op_face = FACE_NEG_Z; w.jc = J_LAST; w.target = ST_IDLE;
      end
      ST_EM1: begin
        w.emit = EM_FACE; w.op_face = FACE_POS_Z; w.jc = J_LAST; w.target = ST_IDLE;
      end
      ST_EM2: begin
        w.emit = EM_FACE; w.op_face = FACE_POS_X; w.jc = J_LAST; w.target = ST_IDLE;
      end
      ST_EM3: begin
        w.emit = EM_FACE; w.op_face = FACE_NEG_X; w.jc = J_LAST; w.target = ST_IDLE;
      end
      ST_EM4: begin
        w.emit = EM_FACE; w.op_face = FACE_POS_Y; w.jc = J_LAST; w.target = ST_IDLE;
      end
      ST_EM5: begin
        w.emit = EM_FACE; w.op_face = FACE_NEG_Y; w.jc = J_ALWAYS; w.target = ST_IDLE;
      end
      ST_CAP0: begin
        w.emit = EM_CAP; w.op_face = CAP_1;
      end
      ST_CAP1: begin
        w.emit = EM_CAP; w.op_face = CAP_2;
      end
      ST_CAP2: begin
        w.emit = EM_CAP; w.op_face = CAP_3;
      end
      ST_CAP3: begin
        w.emit = EM_CAP; w.op_face = CAP_4; w.jc = J_ALWAYS; w.target = ST_IDLE;
      end
      ST_ACK: begin
        w.emit = EM_ACK; w.jc = J_ALWAYS; w.target = ST_IDLE;
      end
      default: begin
        w.jc = J_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ design/vvfc_if.sv @@
// command and result channels of the voxel face culler
// depends on vvfc_pkg
interface vvfc_cmd_if import vvfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [COORD_W-1:0] pos_z;
  logic [KIND_W-1:0]  voxel_kind;

  modport source (output valid, req_type, pos_x, pos_y, pos_z, voxel_kind, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, pos_z, voxel_kind, output ready);
endinterface

interface vvfc_rsp_if import vvfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              face_valid;
  logic [CODE_W-1:0] face_code;
  logic [BASE_W-1:0] base_vertex;
  logic [TEX_W-1:0]  tex_row;
  logic              needs_collider;
  logic              last;

  modport source (output valid, face_valid, face_code, base_vertex, tex_row,
                  needs_collider, last, input ready);
  modport sink   (input valid, face_valid, face_code, base_vertex, tex_row,
                  needs_collider, last, output ready);
endinterface

@@ design/voxel_visible_face_culler_unit.sv @@
// voxel grid store with visible-face culling, run by a microcoded sequencer
// depends on vvfc_pkg, vvfc_if.sv and voxel_visible_face_culler_unit_assert.svh
//
//   channel  dir  payload                                               accepted when
//   cmd      in   req_type pos_x pos_y pos_z voxel_kind                 valid & ready
//   rsp      out  face_valid face_code base_vertex tex_row              valid & ready
//                 needs_collider last
//
// write or out-of-grid item: check step, then ack; empty voxel query: ack after the
// first neighbor read; flower query: four caps; solid voxel query: six neighbor reads
// through the single read port of the voxel memory, then its visible faces in order.
// after reset a clearing pass writes every memory entry empty, one per cycle;
// cmd.ready stays low meanwhile.
// a result waits in the output register; the sequencer holds on an emit step while
// it is full and not taken, and takes the next item while the last result waits.
`include "voxel_visible_face_culler_unit_assert.svh"

module voxel_visible_face_culler_unit import vvfc_pkg::*; #(
  parameter int GRID_X = DEF_GRID_X,
  parameter int GRID_Y = DEF_GRID_Y,
  parameter int GRID_Z = DEF_GRID_Z
) (
  input  logic   clk,
  input  logic   rst,
  vvfc_cmd_if.sink   cmd,
  vvfc_rsp_if.source rsp
);

  // only coordinates the fields can reach are stored
  localparam int SPAN   = 2 ** COORD_W;
  localparam int EX     = (GRID_X < SPAN) ? GRID_X : SPAN;
  localparam int EY     = (GRID_Y < SPAN) ? GRID_Y : SPAN;
  localparam int EZ     = (GRID_Z < SPAN) ? GRID_Z : SPAN;
  localparam int AX     = $clog2(EX);
  localparam int AY     = $clog2(EY);
  localparam int AZ     = $clog2(EZ);
  localparam int ADDR_W = AX + AY + AZ;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam logic [COORD_W:0] LIM_X = (COORD_W + 1)'(EX);
  localparam logic [COORD_W:0] LIM_Y = (COORD_W + 1)'(EY);
  localparam logic [COORD_W:0] LIM_Z = (COORD_W + 1)'(EZ);

  typedef struct packed {
    logic [COORD_W:0] x;
    logic [COORD_W:0] y;
    logic [COORD_W:0] z;
  } nb_t;

  // neighbor coordinates; a step below zero wraps high and falls out of range
  function automatic nb_t nb_coord(input logic [FACE_W-1:0] face,
                                   input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y,
                                   input logic [COORD_W-1:0] z);
    nb_t n;
    n.x = {1'b0, x};
    n.y = {1'b0, y};
    n.z = {1'b0, z};
    unique case (face)
      FACE_NEG_Z: n.z = {1'b0, z} - (COORD_W + 1)'(1);
      FACE_POS_Z: n.z = {1'b0, z} + (COORD_W + 1)'(1);
      FACE_POS_X: n.x = {1'b0, x} + (COORD_W + 1)'(1);
      FACE_NEG_X: n.x = {1'b0, x} - (COORD_W + 1)'(1);
      FACE_POS_Y: n.y = {1'b0, y} + (COORD_W + 1)'(1);
      FACE_NEG_Y: n.y = {1'b0, y} - (COORD_W + 1)'(1);
      default: ;
    endcase
    return n;
  endfunction

  // control registers
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  logic              clearing;
  logic [ADDR_W-1:0] clr_cnt;
  logic              out_valid;

  // payload registers
  logic               req_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic [COORD_W-1:0] z_q;
  logic [KIND_W-1:0]  kind_in_q;
  logic [KIND_W-1:0]  kind_q;
  logic [KIND_W-1:0]  rdata;
  logic [5:0]         open_mask;
  logic               out_face_valid;
  logic [CODE_W-1:0]  out_face_code;
  logic [BASE_W-1:0]  out_base_vertex;
  logic [TEX_W-1:0]   out_tex_row;
  logic               out_needs_collider;
  logic               out_last;

  logic [KIND_W-1:0] mem [DEPTH];

  // datapath signals
  uword_t            uw;
  logic              cmd_acc;
  logic              in_grid;
  logic              bad;
  logic              solid;
  nb_t               nb_rd;
  nb_t               nb_op;
  logic              nb_ok;
  logic [ADDR_W-1:0] ctr_addr;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [KIND_W-1:0] wdata;
  logic              face_last;
  logic              do_emit;
  logic              stall;
  logic              take;
  logic [TEX_W-1:0]  tex;

  assign uw      = ucode(pc);
  assign cmd.ready = !clearing && (pc == ST_IDLE);
  assign cmd_acc = cmd.valid && cmd.ready;

  // request decode
  assign in_grid = ({1'b0, x_q} < LIM_X) && ({1'b0, y_q} < LIM_Y) && ({1'b0, z_q} < LIM_Z);
  assign bad     = !in_grid || (req_q == REQ_WRITE);
  assign solid   = (kind_q == KIND_GROUND) || (kind_q == KIND_TRUNK) || (kind_q == KIND_LEAF);

  // addresses
  assign ctr_addr = {z_q[AZ-1:0], y_q[AY-1:0], x_q[AX-1:0]};
  assign nb_rd    = nb_coord(uw.rd_face, x_q, y_q, z_q);
  assign nb_op    = nb_coord(uw.op_face, x_q, y_q, z_q);
  assign nb_ok    = (nb_op.x < LIM_X) && (nb_op.y < LIM_Y) && (nb_op.z < LIM_Z);
  assign raddr    = uw.rd_nb ? {nb_rd.z[AZ-1:0], nb_rd.y[AY-1:0], nb_rd.x[AX-1:0]}
                             : ctr_addr;

  // memory write: clearing pass or a write item
  assign we    = clearing ||
                 (uw.wr && in_grid && (req_q == REQ_WRITE) && (kind_in_q <= KIND_LEAF));
  assign waddr = clearing ? clr_cnt : ctr_addr;
  assign wdata = clearing ? KIND_EMPTY : kind_in_q;

  // last visible face: no open face above this one
  assign face_last = (open_mask & 6'(6'b111110 << uw.op_face)) == 6'd0;

  assign tex = (kind_q == KIND_TRUNK) ? TEX_TRUNK :
               (kind_q == KIND_LEAF)  ? TEX_LEAF  : TEX_GROUND;

  // emit and stall
  always_comb begin
    case (uw.emit)
      EM_FACE: do_emit = open_mask[uw.op_face];
      EM_CAP:  do_emit = 1'b1;
      EM_ACK:  do_emit = 1'b1;
      default: do_emit = 1'b0;
    endcase
  end
  assign stall = do_emit && out_valid && !rsp.ready;

  // jump condition
  always_comb begin
    unique case (uw.jc)
      J_NEVER:    take = 1'b0;
      J_ALWAYS:   take = 1'b1;
      J_NOACC:    take = !cmd_acc;
      J_BAD:      take = bad;
      J_FLOWER:   take = (rdata == KIND_FLOWER);
      J_NOTSOLID: take = !solid;
      J_MASK0:    take = (open_mask == 6'd0);
      J_LAST:     take = do_emit && face_last;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // step counter, clearing pass and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= ST_IDLE;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
        if (&clr_cnt) begin
          clearing <= 1'b0;
        end
      end
      if (do_emit && !stall) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // voxel memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (uw.rd_ctr || uw.rd_nb) begin
      rdata <= mem[raddr];
    end
  end

  // item capture and per-query state
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      req_q     <= cmd.req_type;
      x_q       <= cmd.pos_x;
      y_q       <= cmd.pos_y;
      z_q       <= cmd.pos_z;
      kind_in_q <= cmd.voxel_kind;
    end
    if (uw.ld_kind) begin
      kind_q <= rdata;
    end
    if (uw.cap_open) begin
      open_mask[uw.op_face] <= !nb_ok || (rdata != KIND_GROUND);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (do_emit && !stall) begin
      case (uw.emit)
        EM_FACE: begin
          out_face_valid     <= 1'b1;
          out_face_code      <= CODE_W'(uw.op_face);
          out_base_vertex    <= FACE_BASE[uw.op_face];
          out_tex_row        <= tex;
          out_needs_collider <= 1'b1;
          out_last           <= face_last;
        end
        EM_CAP: begin
          out_face_valid     <= 1'b1;
          out_face_code      <= CAP_CODE_FIRST + CODE_W'(uw.op_face);
          out_base_vertex    <= CAP_BASE[uw.op_face[1:0]];
          out_tex_row        <= TEX_GROUND;
          out_needs_collider <= 1'b0;
          out_last           <= (uw.op_face == CAP_4);
        end
        default: begin
          out_face_valid     <= 1'b0;
          out_face_code      <= '0;
          out_base_vertex    <= '0;
          out_tex_row        <= TEX_GROUND;
          out_needs_collider <= 1'b0;
          out_last           <= 1'b1;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.face_valid     = out_face_valid;
  assign rsp.face_code      = out_face_code;
  assign rsp.base_vertex    = out_base_vertex;
  assign rsp.tex_row        = out_tex_row;
  assign rsp.needs_collider = out_needs_collider;
  assign rsp.last           = out_last;

  // checks
  `VVFC_ASSERT_NEXT(a_idle_holds, clk, rst, (pc == ST_IDLE) && !cmd_acc, pc == ST_IDLE, "sequencer left idle without an item")
  `VVFC_ASSERT_NOW(a_face_solid, clk, rst, (uw.emit == EM_FACE) && do_emit, solid, "face emitted for a voxel that is not solid")
  `VVFC_ASSERT_NOW(a_clear_done_idle, clk, rst, $fell(clearing), pc == ST_IDLE, "clearing pass ended with the sequencer busy")

endmodule

@@ test/tb_top.sv @@
// self-checking testbench for voxel_visible_face_culler_unit: directed table, then random
// depends on vvfc_pkg, vvfc_if.sv and the culler top level in design/
module tb_top;
  import vvfc_pkg::*;

  localparam int GRID_N      = DEF_GRID_X;
  localparam int RAND_ITEMS  = 250;
  localparam int SQUEEZE_AT  = 40;
  localparam int DRAIN_AT    = 120;
  localparam int STEADY_FROM = 160;
  localparam int STEADY_TO   = 210;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  // one result item of the block
  typedef struct packed {
    logic              face_valid;
    logic [CODE_W-1:0] face_code;
    logic [BASE_W-1:0] base_vertex;
    logic [TEX_W-1:0]  tex_row;
    logic              needs_collider;
    logic              last;
  } face_item_t;

  // one row of the directed table
  typedef struct packed {
    logic               req;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [KIND_W-1:0]  kind;
    logic               typed_ack;
  } stim_row_t;

  localparam logic BY_MODEL  = 1'b0;
  localparam logic TYPED_ACK = 1'b1;

  localparam face_item_t ACK_ITEM = '{face_valid: 1'b0, face_code: '0, base_vertex: '0,
                                      tex_row: '0, needs_collider: 1'b0, last: 1'b1};

  // quad corners indexed by face code: six faces, then the four flower caps
  localparam logic [BASE_W-1:0] CORNER_OF [10] = '{6'd20, 6'd0, 6'd4, 6'd8, 6'd12,
                                                  6'd16, 6'd24, 6'd28, 6'd32, 6'd36};
  localparam logic [FACE_W-1:0] FACE_ORDER [6] = '{FACE_NEG_Z, FACE_POS_Z, FACE_POS_X,
                                                  FACE_NEG_X, FACE_POS_Y, FACE_NEG_Y};
  localparam int STEP_X [6] = '{0, 0, 1, -1, 0, 0};
  localparam int STEP_Y [6] = '{0, 0, 0, 0, 1, -1};
  localparam int STEP_Z [6] = '{-1, 1, 0, 0, 0, 0};

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{REQ_QUERY, 5'd0,  5'd0,  5'd0,  KIND_EMPTY,  TYPED_ACK}, // cleared grid, low corner
    '{REQ_QUERY, 5'd31, 5'd31, 5'd31, 3'd7,        TYPED_ACK}, // cleared grid, high corner
    '{REQ_WRITE, 5'd31, 5'd31, 5'd31, KIND_FLOWER, TYPED_ACK},
    '{REQ_QUERY, 5'd31, 5'd31, 5'd31, KIND_EMPTY,  BY_MODEL},  // four caps
    '{REQ_WRITE, 5'd0,  5'd0,  5'd0,  KIND_GROUND, TYPED_ACK},
    '{REQ_QUERY, 5'd0,  5'd0,  5'd0,  KIND_GROUND, BY_MODEL},  // lone ground, all faces
    '{REQ_WRITE, 5'd0,  5'd0,  5'd0,  3'd7,        TYPED_ACK}, // bad kind, ignored
    '{REQ_WRITE, 5'd1,  5'd0,  5'd0,  3'd5,        TYPED_ACK}, // bad kind, ignored
    '{REQ_QUERY, 5'd1,  5'd0,  5'd0,  KIND_EMPTY,  TYPED_ACK}, // still empty
    '{REQ_WRITE, 5'd31, 5'd0,  5'd31, KIND_TRUNK,  TYPED_ACK},
    '{REQ_QUERY, 5'd31, 5'd0,  5'd31, KIND_EMPTY,  BY_MODEL},
    '{REQ_WRITE, 5'd0,  5'd31, 5'd0,  KIND_LEAF,   TYPED_ACK},
    '{REQ_QUERY, 5'd0,  5'd31, 5'd0,  KIND_EMPTY,  BY_MODEL},
    '{REQ_WRITE, 5'd5,  5'd5,  5'd5,  KIND_LEAF,   TYPED_ACK},
    '{REQ_WRITE, 5'd5,  5'd5,  5'd4,  KIND_GROUND, TYPED_ACK},
    '{REQ_WRITE, 5'd5,  5'd5,  5'd6,  KIND_GROUND, TYPED_ACK},
    '{REQ_WRITE, 5'd6,  5'd5,  5'd5,  KIND_GROUND, TYPED_ACK},
    '{REQ_WRITE, 5'd4,  5'd5,  5'd5,  KIND_GROUND, TYPED_ACK},
    '{REQ_WRITE, 5'd5,  5'd6,  5'd5,  KIND_GROUND, TYPED_ACK},
    '{REQ_WRITE, 5'd5,  5'd4,  5'd5,  KIND_GROUND, TYPED_ACK},
    '{REQ_QUERY, 5'd5,  5'd5,  5'd5,  KIND_EMPTY,  TYPED_ACK}, // buried leaf, no face
    '{REQ_WRITE, 5'd5,  5'd5,  5'd5,  KIND_EMPTY,  TYPED_ACK},
    '{REQ_QUERY, 5'd5,  5'd5,  5'd5,  KIND_EMPTY,  TYPED_ACK},
    '{REQ_QUERY, 5'd5,  5'd5,  5'd6,  KIND_EMPTY,  BY_MODEL}
  };

  logic clk;
  logic rst;
  bit   hold_rsp;
  bit   steady;
  bit   squeeze_go;

  logic [KIND_W-1:0] grid_kind [GRID_N*GRID_N*GRID_N];
  face_item_t        pending_faces [$];
  face_item_t        item_faces [$];

  int errors;
  int writes_sent;
  int queries_sent;
  int faces_seen;
  int acks_seen;

  vvfc_cmd_if cmd_ch ();
  vvfc_rsp_if rsp_ch ();

  voxel_visible_face_culler_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #3200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // neighbor lets the face show when outside the grid or not ground
  function automatic bit face_open(input int nx, input int ny, input int nz);
    if (nx < 0 || nx >= GRID_N || ny < 0 || ny >= GRID_N || nz < 0 || nz >= GRID_N)
      return 1'b1;
    return grid_kind[nx + GRID_N * (ny + GRID_N * nz)] != KIND_GROUND;
  endfunction

  // applies one item to the grid copy and lists the results it causes
  function automatic void cull_voxel(input logic req, input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y,
                                     input logic [COORD_W-1:0] z,
                                     input logic [KIND_W-1:0] kind,
                                     ref face_item_t faces [$]);
    face_item_t        r;
    logic [KIND_W-1:0] here;
    logic [TEX_W-1:0]  tex;
    int                slot_idx;
    slot_idx = int'(x) + GRID_N * (int'(y) + GRID_N * int'(z));
    faces.delete();
    if (req == REQ_WRITE) begin
      if (kind <= KIND_LEAF) grid_kind[slot_idx] = kind;
      faces = {faces, ACK_ITEM};
      return;
    end
    here = grid_kind[slot_idx];
    if (here == KIND_FLOWER) begin
      for (int c = 0; c < 4; c++) begin
        r = '{face_valid: 1'b1, face_code: CAP_CODE_FIRST + CODE_W'(c),
              base_vertex: CORNER_OF[CAP_CODE_FIRST + CODE_W'(c)], tex_row: TEX_GROUND,
              needs_collider: 1'b0, last: 1'b0};
        faces = {faces, r};
      end
    end else if (here == KIND_GROUND || here == KIND_TRUNK || here == KIND_LEAF) begin
      tex = (here == KIND_TRUNK) ? TEX_TRUNK : (here == KIND_LEAF) ? TEX_LEAF : TEX_GROUND;
      for (int f = 0; f < 6; f++) begin
        if (face_open(int'(x) + STEP_X[f], int'(y) + STEP_Y[f], int'(z) + STEP_Z[f])) begin
          r = '{face_valid: 1'b1, face_code: CODE_W'(FACE_ORDER[f]),
                base_vertex: CORNER_OF[FACE_ORDER[f]], tex_row: tex,
                needs_collider: 1'b1, last: 1'b0};
          faces = {faces, r};
        end
      end
    end
    if (faces.size() == 0) begin
      faces = {faces, ACK_ITEM};
    end else begin
      r = faces.pop_back();
      r.last = 1'b1;
      faces = {faces, r};
    end
  endfunction

  // offers one item, waits for the handshake, then records what it should cause
  task automatic send_item(input logic req, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                           input logic [KIND_W-1:0] kind, input logic typed_ack);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.req_type   <= req;
    cmd_ch.pos_x      <= x;
    cmd_ch.pos_y      <= y;
    cmd_ch.pos_z      <= z;
    cmd_ch.voxel_kind <= kind;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    cull_voxel(req, x, y, z, kind, item_faces);
    if (typed_ack) begin
      pending_faces = {pending_faces, ACK_ITEM};
    end else begin
      foreach (item_faces[i]) pending_faces = {pending_faces, item_faces[i]};
    end
    if (req == REQ_WRITE) writes_sent++;
    else queries_sent++;
  endtask

  // random gap on the command side
  task automatic maybe_idle();
    if (!steady && $urandom_range(0, 99) < 18) begin
      do begin
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
      end while ($urandom_range(0, 2) == 0);
    end
  endtask

  // random write kind, ground most often so faces get hidden
  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return KIND_GROUND;
    if (r < 11) return KIND_TRUNK;
    if (r < 14) return KIND_LEAF;
    if (r < 16) return KIND_FLOWER;
    if (r < 18) return KIND_EMPTY;
    return KIND_W'($urandom_range(5, 7));
  endfunction

  // cluster corner: often on a grid edge
  function automatic logic [COORD_W-1:0] pick_corner();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return COORD_W'(GRID_N - 4);
    return COORD_W'($urandom_range(0, GRID_N - 4));
  endfunction

  // result side: random back-pressure, a long hold-off, a steady stretch
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= hold_rsp ? 1'b0 : steady ? 1'b1 : ($urandom_range(0, 99) >= 18);
    end
  end

  // long hold-off on the result side while commands keep coming
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // result check against the oldest expectation
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    face_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_faces.size() == 0) begin
        $error("unexpected result item, code %0d last %0d", rsp_ch.face_code, rsp_ch.last);
        errors++;
      end else begin
        want = pending_faces.pop_front();
        check_field("face_valid", want.face_valid, rsp_ch.face_valid);
        check_field("face_code", want.face_code, rsp_ch.face_code);
        check_field("base_vertex", want.base_vertex, rsp_ch.base_vertex);
        check_field("tex_row", want.tex_row, rsp_ch.tex_row);
        check_field("needs_collider", want.needs_collider, rsp_ch.needs_collider);
        check_field("last", want.last, rsp_ch.last);
        if (want.face_valid) faces_seen++;
        else acks_seen++;
      end
    end
  end

  // stimulus
  initial begin
    logic [COORD_W-1:0] cx, cy, cz;
    logic [COORD_W-1:0] x, y, z;
    logic               req;
    logic [KIND_W-1:0]  kind;
    int                 waited;
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.req_type   = REQ_WRITE;
    cmd_ch.pos_x      = '0;
    cmd_ch.pos_y      = '0;
    cmd_ch.pos_z      = '0;
    cmd_ch.voxel_kind = KIND_EMPTY;
    foreach (grid_kind[i]) grid_kind[i] = KIND_EMPTY;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIR_TABLE[i]) begin
      send_item(DIR_TABLE[i].req, DIR_TABLE[i].x, DIR_TABLE[i].y, DIR_TABLE[i].z,
                DIR_TABLE[i].kind, DIR_TABLE[i].typed_ack);
      maybe_idle();
    end

    // random items, mostly clustered so neighbors interact
    cx = pick_corner();
    cy = pick_corner();
    cz = pick_corner();
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == SQUEEZE_AT) squeeze_go <= 1'b1;
      if (n == STEADY_FROM) steady <= 1'b1;
      if (n == STEADY_TO) steady <= 1'b0;
      // pause until the block has answered everything
      if (n == DRAIN_AT) begin
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_faces.size() != 0) @(posedge clk);
      end
      if (n % 30 == 0) begin
        cx = pick_corner();
        cy = pick_corner();
        cz = pick_corner();
      end
      if ($urandom_range(0, 9) < 8) begin
        x = cx + COORD_W'($urandom_range(0, 3));
        y = cy + COORD_W'($urandom_range(0, 3));
        z = cz + COORD_W'($urandom_range(0, 3));
      end else begin
        x = COORD_W'($urandom_range(0, GRID_N - 1));
        y = COORD_W'($urandom_range(0, GRID_N - 1));
        z = COORD_W'($urandom_range(0, GRID_N - 1));
      end
      req  = ($urandom_range(0, 1) == 0) ? REQ_WRITE : REQ_QUERY;
      kind = (req == REQ_WRITE) ? pick_kind() : KIND_W'($urandom_range(0, 7));
      send_item(req, x, y, z, kind, BY_MODEL);
      maybe_idle();
    end
    cmd_ch.valid <= 1'b0;

    // drain, then let any stray result show up
    waited = 0;
    while (pending_faces.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_faces.size() != 0) begin
      $error("%0d expected result items never arrived", pending_faces.size());
      errors++;
    end

    $display("sent %0d writes and %0d queries; checked %0d faces and %0d acks",
             writes_sent, queries_sent, faces_seen, acks_seen);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/vvfc_pkg.sv
design/vvfc_if.sv
design/voxel_visible_face_culler_unit.sv
test/tb_top.sv
